FILE: hdl/sorted_list_table_macros.svh
// Assertion helpers for the sorted list table.
`ifndef SORTED_LIST_TABLE_MACROS_SVH
`define SORTED_LIST_TABLE_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define SLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list table check failed");

// Next-cycle implication, clocked on clk, quiet during reset.
`define SLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list table check failed");

`endif

FILE: hdl/slt_pkg.sv
package slt_pkg;

  localparam int CAPACITY = 64;
  localparam int VALUE_W  = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam logic [2:0] F_INSERT    = 3'd0;
  localparam logic [2:0] F_REMOVE    = 3'd1;
  localparam logic [2:0] F_FIND      = 3'd2;
  localparam logic [2:0] F_REMOVE_AT = 3'd3;
  localparam logic [2:0] F_READ_AT   = 3'd4;
  localparam logic [2:0] F_CLEAR     = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                      ins;      // insert this cycle
    logic                      del_val;  // remove by value this cycle
    logic                      del_pos;  // remove at position this cycle
    logic                      hit;      // value present (remove by value)
    logic [CNT_W-1:0]          count;    // entries held
    logic [CNT_W-1:0]          del_idx;  // 0-based index for remove at
    logic signed [VALUE_W-1:0] value;    // key under test
  } cmd_t;

endpackage

FILE: hdl/sorted_list_table.sv
// Sorted list table: holds up to 64 signed 32-bit values in ascending order,
// one value per cell in a row of cells. Each request (insert, remove by value,
// find, remove at position, read at position, clear) is taken when the block
// is free, executed once the result register has room, and answered with one
// result carrying status, find position, read value and the new entry count.
// The request is first registered; when it executes, every cell compares its
// entry with the key and shifts left or right at once. The input is free again
// once the request executes, so a result left waiting stalls the request
// behind it and holds off the ones after. Entries past the count are never
// read, so no clearing pass is needed after reset.
module sorted_list_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        func,
  input  logic signed [31:0]                value,
  input  logic [6:0]                        position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        status,
  output logic signed [7:0]                 found_position,
  output logic signed [31:0]                entry_value,
  output logic [6:0]                        count
);

  `include "sorted_list_table_macros.svh"

  localparam int CAP = slt_pkg::CAPACITY;
  localparam int CW  = slt_pkg::CNT_W;
  localparam int VW  = slt_pkg::VALUE_W;

  // request register
  logic                 busy;
  logic [2:0]           op_func;
  logic signed [VW-1:0] op_value;
  logic [6:0]           op_pos;

  // table occupancy
  logic [CW-1:0]        entry_count;
  logic [CW-1:0]        entry_count_next;

  // cell row
  slt_pkg::cmd_t        cmd;
  logic signed [VW-1:0] cell_entry [CAP];
  logic [CAP-1:0]       cell_lt;
  logic [CAP-1:0]       cell_eq;

  logic                 fire;
  logic                 full;
  logic                 pos_ok;
  logic [CW-1:0]        pos_idx;
  logic [CW-1:0]        low_idx;   // entries strictly below the key
  logic                 hit;
  logic signed [VW-1:0] read_data;
  logic [7:0]           find_pos;
  logic [1:0]           status_next;

  // The request executes when the result register is free or being emptied.
  assign fire     = busy && (!out_valid || out_ready);
  assign in_ready = !busy;

  assign full    = entry_count == CW'(CAP);
  assign pos_idx = CW'(op_pos) - CW'(1);
  assign pos_ok  = (op_pos != 7'd0) && (CW'(op_pos) <= entry_count);

  // lt is a thermometer over the valid cells: the slot is the first cell that
  // is not below the key, or one past the end when all are below.
  always_comb begin
    low_idx   = '0;
    hit       = 1'b0;
    read_data = '0;
    for (int i = 0; i < CAP; i++) begin
      if (((i == 0) || cell_lt[(i == 0) ? 0 : i - 1]) && !cell_lt[i]) begin
        low_idx = low_idx | CW'(i);
        hit     = hit | cell_eq[i];
      end
      if (pos_idx == CW'(i)) begin
        read_data = read_data | cell_entry[i];
      end
    end
    if (cell_lt[CAP-1]) begin
      low_idx = CW'(CAP);
    end
  end

  always_comb begin
    cmd.ins     = fire && (op_func == slt_pkg::F_INSERT) && !full;
    cmd.del_val = fire && (op_func == slt_pkg::F_REMOVE);
    cmd.del_pos = fire && (op_func == slt_pkg::F_REMOVE_AT) && pos_ok;
    cmd.hit     = hit;
    cmd.count   = entry_count;
    cmd.del_idx = pos_idx;
    cmd.value   = op_value;
  end

  for (genvar g = 0; g < CAP; g++) begin : g_cell
    if (g == 0) begin : g_head
      slt_cell u_cell (
        .clk         (clk),
        .idx         (slt_pkg::IDX_W'(g)),
        .cmd         (cmd),
        .left_entry  (op_value),
        .left_lt     (1'b1),
        .right_entry (cell_entry[(CAP > 1) ? 1 : 0]),
        .entry       (cell_entry[g]),
        .lt          (cell_lt[g]),
        .eq          (cell_eq[g])
      );
    end else if (g == CAP - 1) begin : g_tail
      slt_cell u_cell (
        .clk         (clk),
        .idx         (slt_pkg::IDX_W'(g)),
        .cmd         (cmd),
        .left_entry  (cell_entry[g-1]),
        .left_lt     (cell_lt[g-1]),
        .right_entry (cell_entry[g]),
        .entry       (cell_entry[g]),
        .lt          (cell_lt[g]),
        .eq          (cell_eq[g])
      );
    end else begin : g_mid
      slt_cell u_cell (
        .clk         (clk),
        .idx         (slt_pkg::IDX_W'(g)),
        .cmd         (cmd),
        .left_entry  (cell_entry[g-1]),
        .left_lt     (cell_lt[g-1]),
        .right_entry (cell_entry[g+1]),
        .entry       (cell_entry[g]),
        .lt          (cell_lt[g]),
        .eq          (cell_eq[g])
      );
    end
  end

  // found: 1-based slot, negated when the key is absent
  always_comb begin
    find_pos = 8'(low_idx) + 8'd1;
    if (!hit) begin
      find_pos = 8'd0 - find_pos;
    end
  end

  always_comb begin
    entry_count_next = entry_count;
    status_next      = slt_pkg::ST_OK;
    case (op_func)
      slt_pkg::F_INSERT: begin
        if (full) begin
          status_next = slt_pkg::ST_FULL;
        end else begin
          entry_count_next = entry_count + CW'(1);
        end
      end
      slt_pkg::F_REMOVE: begin
        if (hit) begin
          entry_count_next = entry_count - CW'(1);
        end else begin
          status_next = slt_pkg::ST_MISS;
        end
      end
      slt_pkg::F_FIND: begin
        status_next = slt_pkg::ST_OK;
      end
      slt_pkg::F_REMOVE_AT: begin
        if (pos_ok) begin
          entry_count_next = entry_count - CW'(1);
        end else begin
          status_next = slt_pkg::ST_MISS;
        end
      end
      slt_pkg::F_READ_AT: begin
        if (!pos_ok) begin
          status_next = slt_pkg::ST_MISS;
        end
      end
      slt_pkg::F_CLEAR: begin
        entry_count_next = '0;
      end
      default: begin
        status_next = slt_pkg::ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      out_valid   <= 1'b0;
      entry_count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
      end
      if (fire) begin
        out_valid   <= 1'b1;
        entry_count <= entry_count_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_func  <= func;
      op_value <= value;
      op_pos   <= position;
    end
    if (fire) begin
      status         <= status_next;
      found_position <= (op_func == slt_pkg::F_FIND) ? find_pos : 8'sd0;
      entry_value    <= ((op_func == slt_pkg::F_READ_AT) && pos_ok) ? read_data : 32'sd0;
      count          <= 7'(entry_count_next);
    end
  end

  `SLT_ASSERT_NOW(a_count_bound, 1'b1, entry_count <= CW'(CAP))
  `SLT_ASSERT_NEXT(a_hold_when_stalled, busy && out_valid && !out_ready, busy)
  `SLT_ASSERT_NEXT(a_full_keeps_count, fire && (op_func == slt_pkg::F_INSERT) && full, entry_count == $past(entry_count))
  `SLT_ASSERT_NOW(a_result_from_fire, $rose(out_valid), $past(fire))

endmodule

FILE: hdl/slt_cell.sv
module slt_cell (
  input  logic                              clk,
  input  logic [slt_pkg::IDX_W-1:0]         idx,
  input  slt_pkg::cmd_t                     cmd,
  input  logic signed [slt_pkg::VALUE_W-1:0] left_entry,
  input  logic                              left_lt,
  input  logic signed [slt_pkg::VALUE_W-1:0] right_entry,
  output logic signed [slt_pkg::VALUE_W-1:0] entry,
  output logic                              lt,
  output logic                              eq
);

  logic valid;
  logic shift_in;
  logic shift_out;

  always_comb begin
    valid     = slt_pkg::CNT_W'(idx) < cmd.count;
    lt        = valid && (entry < cmd.value);
    eq        = valid && (entry == cmd.value);
    // on insert, every cell at or after the slot moves one place right
    shift_in  = cmd.ins && !lt;
    // on removal, every cell from the hole onwards pulls from the right
    shift_out = (cmd.del_val && cmd.hit && !lt) ||
                (cmd.del_pos && (slt_pkg::CNT_W'(idx) >= cmd.del_idx));
  end

  always_ff @(posedge clk) begin
    if (shift_in) begin
      entry <= left_lt ? cmd.value : left_entry;
    end else if (shift_out) begin
      entry <= right_entry;
    end
  end

endmodule

FILE: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // func codes 6 and 7 are unused by the block and must be refused
  localparam logic [2:0] F_UNUSED_6 = 3'd6;
  localparam logic [2:0] F_UNUSED_7 = 3'd7;

  // cycles with no handshake on either side before the run is called hung
  localparam int QUIET_LIMIT = 4000;
  // mismatch lines printed before going quiet (counting carries on)
  localparam int PRINT_CAP = 40;

  // operation mix of a stimulus phase
  typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIXED} table_trend_t;

  // one answer of the table, at the port widths
  typedef struct {
    logic [1:0]         status;
    logic signed [7:0]  found_position;
    logic signed [31:0] entry_value;
    logic [6:0]         count;
  } table_answer_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: keeps its own ascending copy of the table, predicts the answer
  // to every accepted request and matches answers in arrival order.
  // ---------------------------------------------------------------------------
  class sorted_table_scoreboard;
    int            held[$];     // ascending copy of the table
    table_answer_t awaited[$];  // answers owed, oldest first
    int errors, n_requests, n_results, n_full, n_hits, peak;

    // entries strictly below v, i.e. the 0-based insertion slot
    function int lower_slot(int v);
      int i;
      i = 0;
      while (i < held.size() && held[i] < v) i++;
      return i;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_request(logic [2:0] op, logic signed [31:0] v, logic [6:0] pos);
      table_answer_t a;
      int slot;
      a.status = slt_pkg::ST_OK;
      a.found_position = '0;
      a.entry_value = '0;
      n_requests++;
      case (op)
        slt_pkg::F_INSERT: begin
          if (held.size() >= slt_pkg::CAPACITY) begin
            a.status = slt_pkg::ST_FULL;
            n_full++;
          end else begin
            slot = lower_slot(v);
            held.insert(slot, v);
          end
        end
        slt_pkg::F_REMOVE: begin
          slot = lower_slot(v);
          if (slot < held.size() && held[slot] == v) begin
            held.delete(slot);
            n_hits++;
          end else begin
            a.status = slt_pkg::ST_MISS;
          end
        end
        slt_pkg::F_FIND: begin
          // position if present, else minus the insertion position
          slot = lower_slot(v);
          if (slot < held.size() && held[slot] == v) begin
            a.found_position = 8'(slot + 1);
            n_hits++;
          end else begin
            a.found_position = 8'(-(slot + 1));
          end
        end
        slt_pkg::F_REMOVE_AT: begin
          if (pos >= 1 && pos <= held.size()) held.delete(pos - 1);
          else a.status = slt_pkg::ST_MISS;
        end
        slt_pkg::F_READ_AT: begin
          if (pos >= 1 && pos <= held.size()) a.entry_value = held[pos - 1];
          else a.status = slt_pkg::ST_MISS;
        end
        slt_pkg::F_CLEAR: held.delete();
        default: a.status = slt_pkg::ST_MISS;
      endcase
      a.count = 7'(held.size());
      if (held.size() > peak) peak = held.size();
      awaited.push_back(a);
    endfunction

    task report(string what, longint want, longint got);
      errors++;
      if (errors <= PRINT_CAP)
        $display("[%0t] mismatch on result %0d: %s expected %0d, got %0d",
                 $realtime, n_results, what, want, got);
    endtask

    task check_result(table_answer_t got);
      table_answer_t want;
      n_results++;
      if (awaited.size() == 0) begin
        report("result with no request outstanding, status", -1, got.status);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.found_position !== want.found_position)
        report("found_position", want.found_position, got.found_position);
      if (got.entry_value !== want.entry_value)
        report("entry_value", want.entry_value, got.entry_value);
      if (got.count !== want.count) report("count", want.count, got.count);
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         func = slt_pkg::F_INSERT;
  logic signed [31:0] value = '0;
  logic [6:0]         position = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic signed [7:0]  found_position;
  logic signed [31:0] entry_value;
  logic [6:0]         count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_list_table dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .value          (value),
    .position       (position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_position (found_position),
    .entry_value    (entry_value),
    .count          (count)
  );

  sorted_table_scoreboard sb = new();

  // idling mix of the current phase, in percent per cycle
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, and every accepted result is checked.
  // Values are read just after the edge, so they are the ones the edge saw.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : result_check
    table_answer_t got;
    if (!rst && out_valid && out_ready) begin
      got.status         = status;
      got.found_position = found_position;
      got.entry_value    = entry_value;
      got.count          = count;
      sb.check_result(got);
    end
  end

  // Watchdog: any handshake resets the quiet count.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Presents one request, after a random idle gap, and returns on the edge at
  // which it is taken. Valid is left high so a back-to-back request follows
  // without a bubble.
  task automatic send_request(input logic [2:0] op, input logic signed [31:0] v,
                              input logic [6:0] pos);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    value    <= v;
    position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, v, pos);
  endtask

  // Drops valid and holds off until every answer owed has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [2:0] pick_op(table_trend_t trend);
    int w[7];
    int r, acc, k;
    logic [2:0] ops[7];
    ops = '{slt_pkg::F_INSERT, slt_pkg::F_REMOVE, slt_pkg::F_FIND, slt_pkg::F_REMOVE_AT,
            slt_pkg::F_READ_AT, slt_pkg::F_CLEAR, F_UNUSED_6};
    case (trend)
      TREND_GROW:   w = '{650, 80, 90, 60, 90, 5, 25};
      TREND_SHRINK: w = '{200, 250, 100, 250, 150, 15, 35};
      default:      w = '{400, 150, 150, 100, 150, 20, 30};
    endcase
    r = $urandom_range(0, 999);
    acc = 0;
    for (k = 0; k < 7; k++) begin
      acc += w[k];
      if (r < acc) begin
        if (k == 6) return $urandom_range(0, 1) ? F_UNUSED_7 : F_UNUSED_6;
        return ops[k];
      end
    end
    return slt_pkg::F_FIND;
  endfunction

  // Keys: a quarter are already in the table (hits and duplicates), a quarter
  // come from a narrow band so collisions are common, the rest are full range
  // or the corners of the signed range.
  function automatic logic signed [31:0] pick_value();
    int n, tmp;
    n = sb.held.size();
    case ($urandom_range(0, 3))
      0: return (n > 0) ? sb.held[$urandom_range(0, n - 1)] : $urandom;
      1: begin
        tmp = $urandom_range(0, 32);
        return tmp - 16;
      end
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'sh8000_0000;
          1: return 32'sh8000_0001;
          2: return 32'sh7FFF_FFFF;
          3: return 32'sh7FFF_FFFE;
          4: return -32'sd1;
          default: return 32'sd0;
        endcase
      end
    endcase
  endfunction

  // Mostly a valid position, sometimes just outside, sometimes anything.
  function automatic logic [6:0] pick_position();
    int n, r;
    n = sb.held.size();
    r = $urandom_range(0, 9);
    if (r < 8) return 7'($urandom_range(1, (n > 0) ? n : 1));
    if (r == 8) return $urandom_range(0, 1) ? 7'd0 : 7'(n + 1);
    return 7'($urandom_range(0, 127));
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  int           phase_tx[8]    = '{0, 74, 0, 21, 0, 74, 0, 21};
  int           phase_rx[8]    = '{0, 0, 74, 21, 0, 0, 74, 21};
  table_trend_t phase_trend[8] = '{TREND_GROW, TREND_GROW, TREND_MIXED, TREND_SHRINK,
                                   TREND_MIXED, TREND_GROW, TREND_SHRINK, TREND_MIXED};

  initial begin : stimulus
    int ph, i;
    logic [2:0] op;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, signed extremes, duplicates, present and absent
    // keys, positions at and around both ends, unused codes, clear.
    send_request(slt_pkg::F_FIND,      32'sd0,          7'd0);
    send_request(slt_pkg::F_REMOVE,    32'sd5,          7'd1);
    send_request(slt_pkg::F_READ_AT,   32'sd0,          7'd1);
    send_request(slt_pkg::F_REMOVE_AT, 32'sd0,          7'd0);
    send_request(slt_pkg::F_INSERT,    32'sd0,          7'd0);
    send_request(slt_pkg::F_INSERT,    32'sh7FFF_FFFF,  7'd127);
    send_request(slt_pkg::F_INSERT,    32'sh8000_0000,  7'd0);
    send_request(slt_pkg::F_INSERT,    -32'sd1,         7'd64);
    send_request(slt_pkg::F_INSERT,    32'sd0,          7'd0);
    send_request(slt_pkg::F_FIND,      32'sd0,          7'd0);
    send_request(slt_pkg::F_FIND,      32'sd1,          7'd0);
    send_request(slt_pkg::F_FIND,      32'sh7FFF_FFFF,  7'd0);
    send_request(slt_pkg::F_FIND,      32'sh8000_0000,  7'd0);
    send_request(slt_pkg::F_READ_AT,   32'sd0,          7'd0);
    send_request(slt_pkg::F_READ_AT,   32'sd0,          7'd1);
    send_request(slt_pkg::F_READ_AT,   32'sd0,          7'd5);
    send_request(slt_pkg::F_READ_AT,   32'sd0,          7'd6);
    send_request(slt_pkg::F_READ_AT,   -32'sd1,         7'd127);
    send_request(slt_pkg::F_REMOVE_AT, 32'sd0,          7'd5);
    send_request(slt_pkg::F_REMOVE,    32'sd0,          7'd0);
    send_request(slt_pkg::F_REMOVE,    32'sd12345,      7'd0);
    send_request(F_UNUSED_6,           32'sh7FFF_FFFF,  7'd127);
    send_request(F_UNUSED_7,           32'sh8000_0000,  7'd1);
    send_request(slt_pkg::F_REMOVE_AT, 32'sd0,          7'd1);
    send_request(slt_pkg::F_CLEAR,     -32'sd1,         7'd127);
    hold_until_drained();

    // Random phases, each with its own idling mix and operation trend. The
    // growing phases push the table to full so refused inserts get exercised.
    for (ph = 0; ph < 8; ph++) begin
      tx_idle_pct  = phase_tx[ph];
      rx_stall_pct = phase_rx[ph];
      for (i = 0; i < 160; i++) begin
        op = pick_op(phase_trend[ph]);
        send_request(op, pick_value(), pick_position());
      end
      hold_until_drained();
    end

    // Let any stray result show itself before the verdict.
    repeat (8) @(posedge clk);

    $display("Checked %0d requests and %0d results across four idling mixes.",
             sb.n_requests, sb.n_results);
    $display("Peak fill %0d of %0d, %0d inserts refused when full, %0d key hits.",
             sb.peak, slt_pkg::CAPACITY, sb.n_full, sb.n_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d answers outstanding", sb.errors, sb.pending());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
